// File: src/phe_pkg.sv
package phe_pkg;

    localparam int DATA_W     = 32;
    localparam int COEF_SLOTS = 7;
    localparam int ADDR_W     = 5;

    typedef enum logic [2:0] {
        REG_TERM_COUNT = 3'd0,
        REG_COEF_0     = 3'd1,
        REG_COEF_1     = 3'd2,
        REG_COEF_2     = 3'd3,
        REG_COEF_3     = 3'd4,
        REG_COEF_4     = 3'd5,
        REG_COEF_5     = 3'd6,
        REG_COEF_6     = 3'd7
    } reg_idx_t;

endpackage

// File: src/polynomial_horner_eval.sv
// Channel   Direction  Word                                   Handshake
// s_        in         tdata[31:0] sample_x                   tvalid / tready
// m_        out        tdata[31:0] poly_value, tuser overflow tvalid / tready
// apb       in/out     term_count and coef_0..coef_6          psel / penable / pready
//
// One word is accepted per cycle while the output is not stalled. The pipeline is an input
// register, then one multiply stage and one shift, add and saturate stage per Horner step.
// Reset is synchronous and active low; it clears the valid bits and the coefficients
// and sets term_count to one, but not the data path. A stall at the output freezes the
// whole pipeline; s_tready is low only while a finished word waits unread at the output.
module polynomial_horner_eval
    import phe_pkg::*;
#(
    parameter int MAX_TERMS = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [31:0] sample_x
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,   // [31:0] poly_value
    output logic [0:0]          m_tuser,   // [0] overflow
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int          LAST  = MAX_TERMS - 1;
    localparam logic [2:0]  MAX_N = 3'(MAX_TERMS);
    localparam int          PW    = 2 * DATA_W;

    logic [2:0]                term_count_reg;
    logic signed [DATA_W-1:0]  coef_reg [COEF_SLOTS];
    logic [2:0]                n_eff;
    logic                      adv;
    reg_idx_t                  wr_idx;
    reg_idx_t                  rd_idx;

    logic signed [DATA_W-1:0]  acc_reg [MAX_TERMS];
    logic signed [DATA_W-1:0]  x_reg   [MAX_TERMS];
    logic                      ovf_reg [MAX_TERMS];
    logic                      vld_reg [MAX_TERMS];

    assign pready = 1'b1;
    assign wr_idx = reg_idx_t'(paddr[4:2]);
    assign rd_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_count_reg <= 3'd1;
            for (int i = 0; i < COEF_SLOTS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            if (wr_idx == REG_TERM_COUNT) begin
                term_count_reg <= pwdata[2:0];
            end else begin
                coef_reg[3'(paddr[4:2] - 3'd1)] <= pwdata;
            end
        end
    end

    always_comb begin
        unique case (rd_idx)
            REG_TERM_COUNT: prdata = {{(DATA_W-3){1'b0}}, term_count_reg};
            REG_COEF_0:     prdata = coef_reg[0];
            REG_COEF_1:     prdata = coef_reg[1];
            REG_COEF_2:     prdata = coef_reg[2];
            REG_COEF_3:     prdata = coef_reg[3];
            REG_COEF_4:     prdata = coef_reg[4];
            REG_COEF_5:     prdata = coef_reg[5];
            REG_COEF_6:     prdata = coef_reg[6];
            default:        prdata = '0;
        endcase
    end

    // A term count of zero behaves as one; counts above MAX_TERMS are clamped to MAX_TERMS.
    always_comb begin
        if (term_count_reg == 3'd0) begin
            n_eff = 3'd1;
        end else if (term_count_reg > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = term_count_reg;
        end
    end

    assign adv      = !vld_reg[LAST] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            acc_reg[0] <= coef_reg[0];
            x_reg[0]   <= s_tdata;
            ovf_reg[0] <= 1'b0;
        end
    end

    for (genvar k = 1; k < MAX_TERMS; k++) begin : g_step
        logic signed [PW-1:0]      prod_reg;
        logic signed [DATA_W-1:0]  accm_reg;
        logic signed [DATA_W-1:0]  xm_reg;
        logic                      ovfm_reg;
        logic                      vldm_reg;
        logic signed [PW-1:0]      shifted;
        logic [PW:0]               sum;
        logic                      in_range;
        logic                      active;
        logic signed [DATA_W-1:0]  acc_next;
        logic                      ovf_next;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vldm_reg   <= 1'b0;
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vldm_reg   <= vld_reg[k-1];
                vld_reg[k] <= vldm_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                prod_reg   <= acc_reg[k-1] * x_reg[k-1];
                accm_reg   <= acc_reg[k-1];
                xm_reg     <= x_reg[k-1];
                ovfm_reg   <= ovf_reg[k-1];
                acc_reg[k] <= acc_next;
                x_reg[k]   <= xm_reg;
                ovf_reg[k] <= ovf_next;
            end
        end

        assign active   = 3'(k) < n_eff;
        assign shifted  = prod_reg >>> FRAC_BITS;
        assign sum      = {shifted[PW-1], shifted}
                        + {{(PW-DATA_W+1){coef_reg[k][DATA_W-1]}}, coef_reg[k]};
        assign in_range = (sum[PW:DATA_W-1] == '0) || (sum[PW:DATA_W-1] == '1);

        always_comb begin
            if (!active) begin
                acc_next = accm_reg;
            end else if (in_range) begin
                acc_next = sum[DATA_W-1:0];
            end else if (sum[PW]) begin
                acc_next = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                acc_next = {1'b0, {(DATA_W-1){1'b1}}};
            end
            ovf_next = ovfm_reg || (active && !in_range);
        end
    end

    assign m_tvalid   = vld_reg[LAST];
    assign m_tdata    = acc_reg[LAST];
    assign m_tuser[0] = ovf_reg[LAST];

endmodule

// File: src/phe_checker.sv
module phe_checker
    import phe_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [DATA_W-1:0]   s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [DATA_W-1:0]   m_tdata,
    input logic [0:0]          m_tuser,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [ADDR_W-1:0]   paddr,
    input logic [DATA_W-1:0]   pwdata,
    input logic [DATA_W-1:0]   prdata,
    input logic                pready
);

    // A word held at the output keeps its value until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // The input side is only held off by an unread output word.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with a free pipeline");

    // No output word appears straight after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A coefficient written is read back unchanged.
    a_coef_rb: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[4:2] != REG_TERM_COUNT)
        ##1 (psel && !pwrite && paddr == $past(paddr))
        |-> prdata == $past(pwdata))
        else $error("coefficient read-back mismatch");

endmodule

bind polynomial_horner_eval phe_checker u_phe_checker (.*);
